// ===== rtl/core/fsfl_pkg.sv =====
// Shared types and codes for the fixed slot free list allocator.
// Used by fsfl_ctrl, fsfl_dpath and the top level; depends on nothing.
package fsfl_pkg;

  localparam int unsigned OFS_W  = 17;
  localparam int unsigned CNT_W  = 15;
  localparam int unsigned FUNC_W = 2;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned CFGI_W = 2;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam logic [OFS_W-1:0] MIN_STRIDE = OFS_W'(4);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ALLOC = 2'd0,
    FUNC_FREE  = 2'd1,
    FUNC_BUILD = 2'd2,
    FUNC_CLEAR = 2'd3
  } func_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_RANGE = 2'd2
  } stat_e;

  typedef enum logic [CFGI_W-1:0] {
    CFG_REGION = 2'd0,
    CFG_STRIDE = 2'd1,
    CFG_FIRST  = 2'd2
  } cfg_idx_e;

  // controller -> datapath
  typedef struct packed {
    logic load_item;
    logic do_op;
    logic build_init;
    logic build_step;
    logic build_fin;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_build;
    logic build_more;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/core/fsfl_ctrl.sv =====
// Sequencing FSM of the allocator: accept, execute, build walk.
// Depends on fsfl_pkg.
module fsfl_ctrl import fsfl_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_BUILD = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts_i.is_build) begin
          cmd_o.build_init = 1'b1;
          state_d = S_BUILD;
        end else if (sts_i.out_free) begin
          cmd_o.do_op = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_BUILD: begin
        if (sts_i.build_more) begin
          cmd_o.build_step = 1'b1;
        end else if (sts_i.out_free) begin
          cmd_o.build_fin = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_accept_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == S_EXEC)
    else $error("accepted transfer did not enter execute");

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd_o))
    else $error("more than one command at once");

  a_build_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.build_fin |-> !sts_i.build_more && state_q == S_BUILD)
    else $error("build finished early");

endmodule

// ===== rtl/core/fsfl_dpath.sv =====
// Datapath of the allocator: config registers, head and count, link word
// memory, build walker and result register. Depends on fsfl_pkg.
module fsfl_dpath import fsfl_pkg::*; #(
  parameter int unsigned REGION_BYTES = 65536
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic [CFGI_W-1:0] cfg_index_i,
  input  logic [OFS_W-1:0]  cfg_data_i,
  input  logic [FUNC_W-1:0] func_i,
  input  logic [15:0]       free_offset_i,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [STAT_W-1:0] status_o,
  output logic [15:0]       slot_offset_o,
  output logic [CNT_W-1:0]  free_count_o
);

  // REGION_BYTES is a power of two; link index is (offset / 4) mod depth
  localparam int unsigned DEPTH = REGION_BYTES / 4;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned XW    = (IDX_W + 2 > OFS_W) ? IDX_W + 2 : OFS_W;
  localparam int unsigned RW    = ($clog2(REGION_BYTES + 1) > OFS_W + 1) ?
                                  $clog2(REGION_BYTES + 1) : OFS_W + 1;
  localparam logic [RW-1:0] REGION_LIM = RW'(REGION_BYTES);

  function automatic logic [IDX_W-1:0] link_idx(input logic [OFS_W-1:0] ofs);
    logic [XW-1:0] x;
    x = XW'(ofs);
    return x[IDX_W+1:2];
  endfunction

  logic [OFS_W-1:0]  region_q, stride_q;
  logic [7:0]        first_q;
  logic [OFS_W-1:0]  head_q, head_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [FUNC_W-1:0] func_q;
  logic [15:0]       ofs_q;
  logic [OFS_W-1:0]  rdata_q;
  logic [OFS_W-1:0]  cur_q;
  logic [RW-1:0]     acc_q;
  logic [CNT_W-1:0]  bcnt_q;
  logic              out_valid_q;
  logic [STAT_W-1:0] status_q, status_d;
  logic [15:0]       slot_q, slot_d;
  logic [CNT_W-1:0]  count_q;

  logic [OFS_W-1:0]  link_mem [2**IDX_W];

  logic [OFS_W-1:0]  stride_eff;
  logic [RW-1:0]     region_eff;
  logic [OFS_W-1:0]  cur_next;
  logic              free_ok;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [OFS_W-1:0]  wr_data;
  logic              load_out;

  assign stride_eff = (stride_q < MIN_STRIDE) ? MIN_STRIDE : stride_q;
  assign region_eff = (RW'(region_q) > REGION_LIM) ? REGION_LIM : RW'(region_q);
  assign cur_next   = cur_q + stride_eff;
  assign free_ok    = {1'b0, ofs_q} < region_q;

  assign sts_o.is_build   = func_q == FUNC_BUILD;
  assign sts_o.build_more = acc_q <= region_eff;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_q <= '0;
      stride_q <= MIN_STRIDE;
      first_q  <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_REGION: region_q <= cfg_data_i;
        CFG_STRIDE: stride_q <= cfg_data_i;
        CFG_FIRST:  first_q  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    head_d   = head_q;
    cnt_d    = cnt_q;
    status_d = STAT_OK;
    slot_d   = '0;
    wr_en    = 1'b0;
    wr_addr  = link_idx(cur_q);
    wr_data  = cur_next;
    load_out = cmd_i.do_op || cmd_i.build_fin;
    if (cmd_i.do_op) begin
      unique case (func_q)
        FUNC_ALLOC: begin
          if (cnt_q == '0) begin
            status_d = STAT_EMPTY;
          end else begin
            slot_d = head_q[15:0];
            head_d = rdata_q;
            cnt_d  = cnt_q - CNT_W'(1);
          end
        end
        FUNC_FREE: begin
          if (!free_ok) begin
            status_d = STAT_RANGE;
          end else begin
            wr_en   = 1'b1;
            wr_addr = link_idx({1'b0, ofs_q});
            wr_data = head_q;
            head_d  = {1'b0, ofs_q};
            if (cnt_q != CNT_MAX) begin
              cnt_d = cnt_q + CNT_W'(1);
            end
          end
        end
        FUNC_CLEAR: begin
          head_d = '0;
          cnt_d  = '0;
        end
        default: ;
      endcase
    end else if (cmd_i.build_step) begin
      wr_en = 1'b1;
    end else if (cmd_i.build_fin) begin
      head_d = OFS_W'(first_q);
      cnt_d  = bcnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      head_q <= head_d;
      cnt_q  <= cnt_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      func_q <= func_i;
      ofs_q  <= free_offset_i;
    end
    if (cmd_i.build_init) begin
      cur_q  <= OFS_W'(first_q);
      acc_q  <= RW'(stride_eff);
      bcnt_q <= '0;
    end else if (cmd_i.build_step) begin
      cur_q  <= cur_next;
      acc_q  <= acc_q + RW'(stride_eff);
      bcnt_q <= bcnt_q + CNT_W'(1);
    end
    if (load_out) begin
      status_q <= status_d;
      slot_q   <= slot_d;
      count_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      link_mem[wr_addr] <= wr_data;
    end
    if (cmd_i.load_item) begin
      rdata_q <= link_mem[link_idx(head_q)];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign slot_offset_o = slot_q;
  assign free_count_o  = count_q;

  a_alloc_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.do_op && func_q == FUNC_ALLOC && cnt_q != '0
    |=> cnt_q == $past(cnt_q) - CNT_W'(1))
    else $error("allocate did not decrement free count");

  a_free_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.do_op && func_q == FUNC_FREE && free_ok
    |=> head_q == {1'b0, $past(ofs_q)})
    else $error("free did not push offset");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> !out_valid_q || out_ready_i)
    else $error("result register overwritten");

  a_count_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && $past(load_out) |-> count_q == cnt_q)
    else $error("reported count differs from state");

endmodule

// ===== rtl/core/fixed_slot_free_list_allocator.sv =====
// Top level of the fixed slot free list allocator.
// Depends on fsfl_pkg, fsfl_ctrl and fsfl_dpath.
//
//   channel  direction  handshake             payload
//   cfg      in         cfg_valid/cfg_ready   cfg_index_i, cfg_data_i
//   in       in         in_valid/in_ready     func_i, free_offset_i
//   out      out        out_valid/out_ready   status_o, slot_offset_o, free_count_o
//
// Allocate, free and clear pass through accept (link read of the head is
// issued here) and execute. Build passes through accept and execute, then walks
// the slots, one link word write per cycle on the single-port link memory.
// A result waits in the output register; the next item is accepted meanwhile
// and waits in execute only if the output register is still full.
// Reset clears head, count, region and first slot and sets stride to MIN_STRIDE; link words are not cleared.
module fixed_slot_free_list_allocator import fsfl_pkg::*; #(
  parameter int unsigned REGION_BYTES = 65536
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CFGI_W-1:0] cfg_index_i,
  input  logic [OFS_W-1:0]  cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [FUNC_W-1:0] func_i,
  input  logic [15:0]       free_offset_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [STAT_W-1:0] status_o,
  output logic [15:0]       slot_offset_o,
  output logic [CNT_W-1:0]  free_count_o
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  fsfl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  fsfl_dpath #(
    .REGION_BYTES (REGION_BYTES)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .func_i        (func_i),
    .free_offset_i (free_offset_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .slot_offset_o (slot_offset_o),
    .free_count_o  (free_count_o)
  );

endmodule
